// File: hw/rtl/sul_pkg.sv
// shared types and constants for the sorted unique list
`timescale 1ns / 1ps

package sul_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  // width of the position and count result fields
  localparam int FLD_W = 5;

  // request kinds
  typedef enum logic [1:0] {
    REQ_ORD    = 2'd0,
    REQ_FRONT  = 2'd1,
    REQ_END    = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  // request broadcast to every cell
  typedef struct packed {
    req_e                     op;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  // data and flags handed from one cell to the next
  typedef struct packed {
    logic signed [VAL_W-1:0]  data;
    logic                     vld;
    logic                     past_k;
    logic                     hit;
  } link_t;

endpackage

// File: hw/rtl/sul_cell.sv
// one list slot: holds an entry, compares it and shifts from its neighbor
`timescale 1ns / 1ps

module sul_cell import sul_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic                     commit_i,
  input  link_t                    prev_i,
  output link_t                    next_o,
  output logic                     sel_o,
  output logic signed [VAL_W-1:0]  data_d_o,
  output logic                     vld_d_o
);

  logic signed [VAL_W-1:0] data_q, data_d;
  logic                    vld_q, vld_d;
  logic                    eq, lt, stop, hit, at_k;

  // local compares against the broadcast value
  assign eq = vld_q & (data_q == cmd_i.value);
  assign lt = cmd_i.value < data_q;

  // insert point and match flags per request kind
  always_comb begin
    unique case (cmd_i.op)
      REQ_ORD: begin
        stop = ~vld_q | lt;
        hit  = eq & ~prev_i.past_k;
      end
      REQ_FRONT: begin
        stop = 1'b1;
        hit  = 1'b0;
      end
      REQ_END: begin
        stop = ~vld_q;
        hit  = 1'b0;
      end
      REQ_SEARCH: begin
        stop = 1'b0;
        hit  = eq;
      end
      default: begin
        stop = 1'b0;
        hit  = 1'b0;
      end
    endcase
  end

  assign at_k = ~prev_i.past_k & stop;

  // chain toward the next cell
  assign next_o.data   = data_q;
  assign next_o.vld    = vld_q;
  assign next_o.past_k = prev_i.past_k | stop;
  assign next_o.hit    = prev_i.hit | hit;

  // one-hot position contribution
  assign sel_o = commit_i ? at_k : (hit & ~prev_i.hit);

  // shift from neighbor behind the insert point, load at it
  always_comb begin
    data_d = data_q;
    vld_d  = vld_q;
    if (commit_i && prev_i.past_k) begin
      data_d = prev_i.data;
      vld_d  = prev_i.vld;
    end else if (commit_i && at_k) begin
      data_d = cmd_i.value;
      vld_d  = 1'b1;
    end
  end

  assign data_d_o = data_d;
  assign vld_d_o  = vld_d;

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/sorted_unique_list.sv
// sorted unique list top level: stream ports, cell row and result register
//
// Holds up to 16 signed 32-bit values in a row of cells, one value per cell.
// Input channel s_axis: tuser carries the request kind (ordered unique
// insert, insert at front, insert at end, search), tdata the value.
// Output channel m_axis: one result per request with added, found,
// position, count, last value, empty and full flags.
// Every cell compares its entry with the request value in the same cycle;
// insert point and first match ripple along the row and the cells behind
// the insert point take their neighbor's entry at the clock edge.
// The result is registered and valid in the cycle after the input transfer;
// one request per cycle is sustained while the receiver does not stall.
// The result register frees when its transfer completes, so a new request
// is taken in the same cycle the receiver takes the old result.
// When the receiver stalls, the held result stays and s_axis_tready is low.
// Reset empties the list at once and clears the output valid; no sweep.
`timescale 1ns / 1ps

module sorted_unique_list import sul_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] value
  input  logic [31:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] added, [1] found, [6:2] position, [11:7] count,
  // [43:12] last_value, [44] empty_res, [45] full_res, [47:46] zero
  output logic [47:0] m_axis_tdata
);

  cmd_t                    cmd;
  link_t                   chain [DEPTH+1];
  logic [DEPTH-1:0]        sel, vld_d, vld_q;
  logic signed [VAL_W-1:0] data_d [DEPTH];
  logic [DEPTH:0]          vld_ext;
  logic                    go, is_ins, full_ref, commit;
  logic [IDX_W-1:0]        pos_enc;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [VAL_W-1:0] last_val;
  logic                    m_vld_q;
  logic [47:0]             m_data_q, m_data_d;

  // input transfer and request decode
  assign s_axis_tready = ~m_vld_q | m_axis_tready;
  assign go            = s_axis_tvalid & s_axis_tready;
  assign cmd.op        = req_e'(s_axis_tuser);
  assign cmd.value     = s_axis_tdata;
  assign is_ins        = cmd.op != REQ_SEARCH;
  assign full_ref      = is_ins & chain[DEPTH].vld;
  assign commit        = go & is_ins & ~full_ref & ~(cmd.op == REQ_ORD & chain[DEPTH].hit);

  // row of cells
  assign chain[0] = '0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sul_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .commit_i (commit),
      .prev_i   (chain[g]),
      .next_o   (chain[g+1]),
      .sel_o    (sel[g]),
      .data_d_o (data_d[g]),
      .vld_d_o  (vld_d[g])
    );
    assign vld_q[g] = chain[g+1].vld;
  end

  // position encode and last entry pick
  assign vld_ext = {1'b0, vld_d};
  always_comb begin
    pos_enc  = '0;
    last_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_enc  = pos_enc | (sel[i] ? IDX_W'(i) : '0);
      last_val = last_val | ((vld_d[i] & ~vld_ext[i+1]) ? data_d[i] : '0);
    end
  end

  assign cnt_d = cnt_q + CNT_W'(commit);

  // result packing
  always_comb begin
    m_data_d        = '0;
    m_data_d[0]     = commit;
    m_data_d[1]     = (cmd.op == REQ_SEARCH) & chain[DEPTH].hit;
    m_data_d[6:2]   = full_ref ? '0 : FLD_W'(pos_enc);
    m_data_d[11:7]  = FLD_W'(cnt_d);
    m_data_d[43:12] = last_val;
    m_data_d[44]    = cnt_d == '0;
    m_data_d[45]    = full_ref;
  end

  // count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      m_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (go) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (go) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // count agrees with the occupied cells
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(vld_q)) == cnt_q)
    else $error("count differs from occupied cells");

  // occupied cells form a prefix of the row
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q >> 1) & ~vld_q) == '0)
    else $error("gap in occupied cells");

  // an insert that lands grows the list by one
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("count did not grow on insert");

  // a result never reports both added and refused
  a_add_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q |-> !(m_data_q[0] && m_data_q[45]))
    else $error("added and full both set");
`endif

endmodule

// File: dv/sorted_unique_list_test.sv
// self-checking stream testbench for the sorted unique list: ordered insert, front/end insert, search
`timescale 1ns / 1ps

module sorted_unique_list_test;
  import sul_pkg::*;

  // result layout on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0]         pad;
    logic               full_res;
    logic               empty_res;
    logic signed [31:0] last_value;
    logic [4:0]         count;
    logic [4:0]         position;
    logic               found;
    logic               added;
  } list_res_t;

  localparam int LONG_HOLD = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [31:0] value
  logic [31:0] s_axis_tdata = '0;
  // [1:0] req_type
  logic [1:0]  s_axis_tuser = REQ_SEARCH;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] added, [1] found, [6:2] position, [11:7] count,
  // [43:12] last_value, [44] empty_res, [45] full_res, [47:46] zero
  logic [47:0] m_axis_tdata;

  // shadow copy of the list and the results still owed by the block
  logic signed [31:0] shadow_list[$];
  list_res_t          owed_res_q[$];

  // stall control shared by sender and receiver
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold_req = 0;

  int n_errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_added = 0;
  int n_refused_full = 0;
  int n_refused_dup = 0;
  int n_hits = 0;
  int n_misses = 0;

  sorted_unique_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // apply one request to the shadow list and work out its result
  function automatic list_res_t predict_list_op(req_e op, logic signed [31:0] v);
    list_res_t r;
    int        n;
    int        k;
    int        i;
    bit        dup;
    r = '0;
    n = shadow_list.size();
    dup = 1'b0;
    if (op == REQ_SEARCH) begin
      for (i = 0; i < n; i++) begin
        if (shadow_list[i] == v) begin
          r.found = 1'b1;
          r.position = i[4:0];
          break;
        end
      end
    end else if (n >= DEPTH) begin
      r.full_res = 1'b1;
    end else if (op == REQ_FRONT) begin
      shadow_list.push_front(v);
      r.added = 1'b1;
    end else if (op == REQ_END) begin
      shadow_list.push_back(v);
      r.position = n[4:0];
      r.added = 1'b1;
    end else if (n == 0 || v < shadow_list[0]) begin
      shadow_list.push_front(v);
      r.added = 1'b1;
    end else begin
      // insert point: first larger value past the head, else the end
      k = n;
      for (i = 1; i < n; i++) begin
        if (v < shadow_list[i]) begin
          k = i;
          break;
        end
      end
      // refuse if the value already sits ahead of the insert point
      for (i = 0; i < k; i++) begin
        if (shadow_list[i] == v) begin
          dup = 1'b1;
          r.position = i[4:0];
          break;
        end
      end
      if (!dup) begin
        shadow_list.insert(k, v);
        r.position = k[4:0];
        r.added = 1'b1;
      end
    end
    n = shadow_list.size();
    r.count = n[4:0];
    r.last_value = (n > 0) ? shadow_list[n-1] : '0;
    r.empty_res = (n == 0);
    return r;
  endfunction

  // offer one request until transfer, then maybe idle for a burst
  task automatic push_request(req_e op, logic [31:0] v);
    list_res_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_list_op(op, v);
    owed_res_q.push_back(r);
    n_sent++;
    if (r.added) n_added++;
    if (r.full_res) n_refused_full++;
    if (op == REQ_ORD && !r.added && !r.full_res) n_refused_dup++;
    if (op == REQ_SEARCH) begin
      if (r.found) n_hits++;
      else n_misses++;
    end
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // sender pause until the block has returned every result
  task automatic wait_all_returned();
    s_axis_tvalid <= 1'b0;
    while (owed_res_q.size() != 0) @(posedge clk_i);
  endtask

  // value mix: extremes, a narrow band for duplicates, list members, single bits, random
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: v = int'($urandom_range(0, 8)) - 4;
      2: v = (shadow_list.size() != 0) ?
             shadow_list[$urandom_range(0, shadow_list.size() - 1)] : $urandom;
      3: v = 32'h1 << $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic req_e pick_op();
    case ($urandom_range(0, 3))
      0: return REQ_ORD;
      1: return REQ_FRONT;
      2: return REQ_END;
      default: return REQ_SEARCH;
    endcase
  endfunction

  // extremes, every kind, duplicate refusal and search miss on a short list
  task automatic test_edge_values();
    push_request(REQ_SEARCH, 32'h0000_0000);
    push_request(REQ_ORD,    32'h0000_0000);
    push_request(REQ_ORD,    32'h8000_0000);
    push_request(REQ_ORD,    32'h7fff_ffff);
    push_request(REQ_ORD,    32'h0000_0000);
    push_request(REQ_ORD,    32'h8000_0000);
    push_request(REQ_FRONT,  32'h0000_0005);
    push_request(REQ_ORD,    32'h0000_0003);
    push_request(REQ_ORD,    32'h0000_0005);
    push_request(REQ_END,    32'hffff_ffff);
    push_request(REQ_SEARCH, 32'h7fff_ffff);
    push_request(REQ_SEARCH, 32'hffff_ffff);
    push_request(REQ_SEARCH, 32'hffff_fffe);
    push_request(REQ_FRONT,  32'hffff_ffff);
    push_request(REQ_SEARCH, 32'hffff_ffff);
    push_request(REQ_SEARCH, 32'h5555_aaaa);
  endtask

  // fill the list with mostly ordered inserts of mixed values
  task automatic test_fill_list();
    req_e op;
    while (shadow_list.size() < DEPTH) begin
      case ($urandom_range(0, 9))
        0: op = REQ_FRONT;
        1: op = REQ_END;
        2: op = REQ_SEARCH;
        default: op = REQ_ORD;
      endcase
      push_request(op, pick_value());
    end
  endtask

  // every insert kind refused on a full list, then searches on it
  task automatic test_full_refusal();
    push_request(REQ_ORD,    32'h8000_0000);
    push_request(REQ_FRONT,  32'h7fff_ffff);
    push_request(REQ_END,    32'h0000_0000);
    push_request(REQ_SEARCH, shadow_list[DEPTH-1]);
    push_request(REQ_SEARCH, shadow_list[0]);
  endtask

  // long receiver hold-off while requests keep coming, then a full drain
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_hold_req = LONG_HOLD;
    repeat (30) push_request(pick_op(), pick_value());
    tx_quiet = 1'b0;
    wait_all_returned();
  endtask

  // random mix with idling on both sides
  task automatic test_random_mix();
    repeat (1800) push_request(pick_op(), pick_value());
  endtask

  // back to back with no idling on either side
  task automatic test_streaming_tail();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (150) push_request(pick_op(), pick_value());
  endtask

  // receiver: random stall bursts, long hold-off on request
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(string fname, logic [31:0] wanted, logic [31:0] seen);
    if (wanted !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, wanted, seen);
      n_errors++;
    end
  endtask

  // compare each result transfer with the oldest owed result
  initial begin : result_checker
    list_res_t seen;
    list_res_t wanted;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        seen = list_res_t'(m_axis_tdata);
        if (owed_res_q.size() == 0) begin
          $display("%0t: result with none owed, expected nothing, actual %0h",
                   $time, m_axis_tdata);
          n_errors++;
        end else begin
          wanted = owed_res_q.pop_front();
          check_field("added",      wanted.added,      seen.added);
          check_field("found",      wanted.found,      seen.found);
          check_field("position",   wanted.position,   seen.position);
          check_field("count",      wanted.count,      seen.count);
          check_field("last_value", wanted.last_value, seen.last_value);
          check_field("empty_res",  wanted.empty_res,  seen.empty_res);
          check_field("full_res",   wanted.full_res,   seen.full_res);
          n_results++;
        end
      end
    end
  end

  // test sequence
  initial begin : test_sequence
    int guard;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_fill_list();
    test_full_refusal();
    test_backpressure();
    test_random_mix();
    test_streaming_tail();
    // drain, then wait for any stray result
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (owed_res_q.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (5) @(posedge clk_i);
    if (owed_res_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_res_q.size());
      n_errors++;
    end
    $display("covered %0d requests, %0d results: %0d inserts placed, %0d duplicates refused",
             n_sent, n_results, n_added, n_refused_dup);
    $display("full-list refusals %0d, search hits %0d, search misses %0d, mismatches %0d",
             n_refused_full, n_hits, n_misses, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sul_pkg.sv
hw/rtl/sul_cell.sv
hw/rtl/sorted_unique_list.sv
dv/sorted_unique_list_test.sv
